FILE: src/bda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII block
// Widths of the channel fields, digit-chain sizing and the cell control bundle.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int VALUE_IN_W  = 32;
    localparam int CHAR_W      = 6;
    localparam int COUNT_W     = 4;

    // decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1
    localparam int DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int CNT_W   = $clog2(DIGITS + 1);
    localparam int POS_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int STEP_W  = $clog2(VALUE_WIDTH);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef struct packed {
        logic clear;
        logic dabble;
        logic emit;
    } t_cell_ctrl;

endpackage

FILE: src/bda_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_ifs: valid/ready channels of the binary to decimal ASCII block
// Input channel carries the binary value, output channel one digit character.
// ----------------------------------------------------------------------------
interface bda_in_if import bda_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [VALUE_IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bda_out_if import bda_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  digit_char;
    logic [COUNT_W-1:0] digit_count;
    logic               last;

    modport source (output valid, output digit_char, output digit_count, output last,
                    input ready);
    modport sink   (input valid, input digit_char, input digit_count, input last,
                    output ready);
endinterface

FILE: src/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII text
// Converts one binary value per transfer into its decimal digits, most
// significant first, without leading zeros (zero gives a single '0').
//
// Channels: i_in carries the value; o_out carries one character per transfer
// with the total digit count and a last flag on the final digit.
// Sequence: each item is loaded, shifted bit-serially through the chain of
// BCD digit cells in VALUE_WIDTH (32) double dabble steps, and counted;
// then each of the DIGITS (10) positions is visited, most significant first,
// one character per significant digit; leading zero positions are skipped
// one a cycle. i_in.ready is high only while no item is in work.
// A stalled receiver holds the output register; the chain waits on it.
// The next item may be accepted while the final character still waits.
// Reset: synchronous, active low; clears the controller and output valid.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bda_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bda_in_if.sink     i_in,
    bda_out_if.source  o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_CNT  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]             r_state,  n_state;
    logic [VALUE_WIDTH-1:0] r_bin,    n_bin;
    logic [STEP_W-1:0]      r_step,   n_step;
    logic [POS_W-1:0]       r_pos,    n_pos;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_out_char,  n_out_char;
    logic [COUNT_W-1:0]     r_out_count, n_out_count;
    logic                   r_out_last,  n_out_last;

    logic [VALUE_WIDTH-1:0] w_value;
    logic [CNT_W-1:0]       w_count;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_skip;
    t_cell_ctrl             w_ctrl;
    logic [DIGITS-1:0]      w_carry;
    logic [3:0]             w_digit [DIGITS];

    generate
        if (VALUE_WIDTH <= VALUE_IN_W) begin : g_narrow
            assign w_value = i_in.value[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign w_value = {{(VALUE_WIDTH - VALUE_IN_W){1'b0}}, i_in.value};
        end
    endgenerate

    // digit chain: cell 0 is least significant
    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++) begin : g_cell
            logic       w_bit_in;
            logic [3:0] w_dig_in;
            if (gi == 0) begin : g_first
                assign w_bit_in = r_bin[VALUE_WIDTH-1];
                assign w_dig_in = 4'd0;
            end else begin : g_next
                assign w_bit_in = w_carry[gi-1];
                assign w_dig_in = w_digit[gi-1];
            end
            bda_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_bit_in),
                .i_digit (w_dig_in),
                .o_carry (w_carry[gi]),
                .o_digit (w_digit[gi])
            );
        end
    endgenerate

    // count significant digits, minimum one
    always_comb begin
        w_count = CNT_W'(1);
        for (int i = 1; i < DIGITS; i++) begin
            if (w_digit[i] != 4'd0) begin
                w_count = CNT_W'(i + 1);
            end
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_skip     = ({{(CNT_W + 1 - POS_W){1'b0}}, r_pos} >= {1'b0, r_count});

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_step      = r_step;
        n_pos       = r_pos;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        w_ctrl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_bin        = w_value;
                    n_step       = '0;
                    w_ctrl.clear = 1'b1;
                    n_state      = S_CONV;
                end
            end
            S_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_bin         = r_bin << 1;
                n_step        = r_step + 1'b1;
                if (r_step == STEP_W'(VALUE_WIDTH - 1)) begin
                    n_state = S_CNT;
                end
            end
            S_CNT: begin
                n_count = w_count;
                n_pos   = POS_W'(DIGITS - 1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_skip) begin
                    w_ctrl.emit = 1'b1;
                    n_pos       = r_pos - 1'b1;
                end else if (w_out_free) begin
                    w_ctrl.emit = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_char  = ASCII_ZERO + {{(CHAR_W - 4){1'b0}}, w_digit[DIGITS-1]};
                    n_out_count = COUNT_W'(r_count);
                    n_out_last  = (r_pos == '0);
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bin       <= n_bin;
        r_step      <= n_step;
        r_pos       <= n_pos;
        r_count     <= n_count;
        r_out_char  <= n_out_char;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digit_char  = r_out_char;
    assign o_out.digit_count = r_out_count;
    assign o_out.last        = r_out_last;

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("output loaded outside emit phase");

    a_char_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char >= ASCII_ZERO) && (r_out_char <= ASCII_ZERO + 6'd9))
        else $error("output character is not a decimal digit");

    a_bin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CNT |-> r_bin == '0)
        else $error("binary value not fully shifted into the chain");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_skip) |-> w_digit[DIGITS-1] == 4'd0)
        else $error("skipped a nonzero leading digit");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> (r_count >= CNT_W'(1)) && (r_count <= CNT_W'(DIGITS)))
        else $error("digit count out of range");

endmodule

FILE: src/bda_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_cell: one BCD digit of the conversion chain
// Add-3 correction and shift during conversion, digit shift-up during output.
// ----------------------------------------------------------------------------
module bda_cell import bda_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_bit,
    input  logic [3:0] i_digit,
    output logic       o_carry,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_corr;

    assign w_corr  = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_corr[3];
    assign o_digit = r_digit;

    always_comb begin
        priority if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_corr[2:0], i_bit};
        end else if (i_ctrl.emit) begin
            n_digit = i_digit;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
